// ----- design/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersection unit
// Field widths, derived datapath widths, status codes and the structs that
// travel between the pipeline sections.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CRD_W  = 32;            // coordinate field width
  localparam int W_W    = CRD_W + 1;     // origin minus centre
  localparam int RAD_W  = 16;
  localparam int ST_W   = 2;
  localparam int DIST_W = 32;

  localparam int A_W    = 2 * CRD_W;     // |v|^2, at most 3 * 2^62
  localparam int H_W    = 2 * CRD_W + 3; // signed sum of three products
  localparam int Q_W    = 2 * CRD_W + 2; // magnitude of a negative h
  localparam int WSQ_W  = 2 * CRD_W + 2; // |o - c|^2
  localparam int RFIX_W = RAD_W + FRAC_BITS;
  localparam int RSQ_W  = 2 * RFIX_W;
  localparam int CMP_W  = (RSQ_W > WSQ_W) ? RSQ_W : WSQ_W;
  localparam int CM_W   = WSQ_W;

  localparam int MUL_SLICES = 3;
  localparam int SLICE_W    = Q_W / MUL_SLICES;
  localparam int PROD_W     = 2 * Q_W;

  localparam int X_W   = PROD_W + 2 * FRAC_BITS; // radicand
  localparam int R_W   = X_W / 2;                // root
  localparam int REM_W = R_W + 2;

  localparam int Y_W   = Q_W + FRAC_BITS;
  localparam int DIV_W = (Y_W > A_W + DIST_W) ? Y_W : A_W + DIST_W;

  typedef enum logic [ST_W-1:0] {
    ST_MISS   = 2'd0,
    ST_HIT    = 2'd1,
    ST_INSIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;  // final status unless calc is set
    logic    calc;    // hit distance still has to be worked out
  } ctl_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] origin_x;
    logic signed [CRD_W-1:0] origin_y;
    logic signed [CRD_W-1:0] origin_z;
    logic signed [CRD_W-1:0] dir_x;
    logic signed [CRD_W-1:0] dir_y;
    logic signed [CRD_W-1:0] dir_z;
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic [RAD_W-1:0]        radius;
  } ray_t;

  typedef struct packed {
    logic [Q_W-1:0]  q;
    logic [A_W-1:0]  a;
    logic [CM_W-1:0] cm;
  } prep_t;

  typedef struct packed {
    logic [Q_W-1:0]    q;
    logic [A_W-1:0]    a;
    logic [PROD_W-1:0] hh;
    logic [PROD_W-1:0] ac;
  } prod_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic [A_W-1:0] a;
    logic [R_W-1:0] root;
    logic           inexact;
  } root_t;

  typedef struct packed {
    status_t           status;
    logic [DIST_W-1:0] distance;
  } rsp_t;

endpackage

// ----- design/rsi_if.sv -----
// ----------------------------------------------------------------------------
// rsi_if: request and response channels of the intersection unit
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rsi_req_if;
  import rsi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] origin_x;
  logic signed [CRD_W-1:0] origin_y;
  logic signed [CRD_W-1:0] origin_z;
  logic signed [CRD_W-1:0] dir_x;
  logic signed [CRD_W-1:0] dir_y;
  logic signed [CRD_W-1:0] dir_z;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic signed [CRD_W-1:0] center_z;
  logic [RAD_W-1:0]        radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface rsi_rsp_if;
  import rsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DIST_W-1:0] distance;

  modport source (output valid, status, distance, input ready);
  modport sink (input valid, status, distance, output ready);
endinterface

// ----- design/rsi_prep.sv -----
// ----------------------------------------------------------------------------
// rsi_prep: quadratic coefficients and early classification
// Five stages: difference, magnitudes, products, sums, classification.
// ----------------------------------------------------------------------------
module rsi_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  rsi_pkg::ray_t  in_ray,
  output rsi_pkg::ctl_t  out_ctl,
  output rsi_pkg::prep_t out_op
);
  import rsi_pkg::*;

  logic signed [CRD_W-1:0] org [3];
  logic signed [CRD_W-1:0] dir [3];
  logic signed [CRD_W-1:0] cen [3];

  logic                    s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [CRD_W-1:0] s1_v [3];
  logic signed [W_W-1:0]   s1_w [3];
  logic [RAD_W-1:0]        s1_rad;
  logic [CRD_W-1:0]        s2_mv [3];
  logic [CRD_W-1:0]        s2_mw [3];
  logic                    s2_neg [3];
  logic [RAD_W-1:0]        s2_rad;
  logic [A_W-1:0]          s3_vv [3];
  logic [A_W-1:0]          s3_ww [3];
  logic [A_W-1:0]          s3_vw [3];
  logic                    s3_neg [3];
  logic [RSQ_W-1:0]        s3_rsq;
  logic [2*RAD_W-1:0]      rad_sq;
  logic [A_W-1:0]          s4_a;
  logic [WSQ_W-1:0]        s4_wsq;
  logic signed [H_W-1:0]   s4_h;
  logic [RSQ_W-1:0]        s4_rsq;
  logic [A_W-1:0]          a_sum;
  logic [WSQ_W-1:0]        wsq_sum;
  logic signed [H_W-1:0]   h_sum;
  logic [CMP_W-1:0]        wsq_e, rsq_e, cm_full;
  logic signed [H_W-1:0]   h_negated;
  ctl_t                    ctl_next;

  assign org[0] = in_ray.origin_x;
  assign org[1] = in_ray.origin_y;
  assign org[2] = in_ray.origin_z;
  assign dir[0] = in_ray.dir_x;
  assign dir[1] = in_ray.dir_y;
  assign dir[2] = in_ray.dir_z;
  assign cen[0] = in_ray.center_x;
  assign cen[1] = in_ray.center_y;
  assign cen[2] = in_ray.center_z;

  assign rad_sq = s2_rad * s2_rad;

  always_comb begin
    a_sum   = '0;
    wsq_sum = '0;
    h_sum   = '0;
    for (int i = 0; i < 3; i++) begin
      a_sum   = a_sum + s3_vv[i];
      wsq_sum = wsq_sum + WSQ_W'(s3_ww[i]);
      if (s3_neg[i]) begin
        h_sum = h_sum - $signed(H_W'(s3_vw[i]));
      end else begin
        h_sum = h_sum + $signed(H_W'(s3_vw[i]));
      end
    end
  end

  assign wsq_e     = CMP_W'(s4_wsq);
  assign rsq_e     = CMP_W'(s4_rsq);
  assign cm_full   = wsq_e - rsq_e;
  assign h_negated = -s4_h;

  // Only a positive c with a negative h needs the square root path.
  always_comb begin
    ctl_next.valid  = s4_valid;
    ctl_next.status = ST_MISS;
    ctl_next.calc   = 1'b0;
    priority if (s4_a == '0) begin
      ctl_next.status = ST_MISS;
    end else if (wsq_e < rsq_e) begin
      ctl_next.status = ST_INSIDE;
    end else if (wsq_e == rsq_e) begin
      ctl_next.status = (s4_h <= 0) ? ST_HIT : ST_MISS;
    end else if (s4_h < 0) begin
      ctl_next.calc = 1'b1;
    end else begin
      ctl_next.status = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      out_ctl  <= '0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      out_ctl  <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_v[i]   <= dir[i];
        s1_w[i]   <= $signed({org[i][CRD_W-1], org[i]}) - $signed({cen[i][CRD_W-1], cen[i]});
        s2_mv[i]  <= s1_v[i][CRD_W-1] ? CRD_W'(-s1_v[i]) : CRD_W'(s1_v[i]);
        s2_mw[i]  <= s1_w[i][W_W-1] ? CRD_W'(-s1_w[i]) : CRD_W'(s1_w[i]);
        s2_neg[i] <= s1_v[i][CRD_W-1] ^ s1_w[i][W_W-1];
        s3_vv[i]  <= s2_mv[i] * s2_mv[i];
        s3_ww[i]  <= s2_mw[i] * s2_mw[i];
        s3_vw[i]  <= s2_mv[i] * s2_mw[i];
        s3_neg[i] <= s2_neg[i];
      end
      s1_rad    <= in_ray.radius;
      s2_rad    <= s1_rad;
      s3_rsq    <= {rad_sq, {(2*FRAC_BITS){1'b0}}};
      s4_a      <= a_sum;
      s4_wsq    <= wsq_sum;
      s4_h      <= h_sum;
      s4_rsq    <= s3_rsq;
      out_op.q  <= h_negated[Q_W-1:0];
      out_op.a  <= s4_a;
      out_op.cm <= cm_full[CM_W-1:0];
    end
  end

endmodule

// ----- design/rsi_mul.sv -----
// ----------------------------------------------------------------------------
// rsi_mul: pipelined products h^2 and a*c
// One slice of the second operand per stage, accumulated over the stages.
// ----------------------------------------------------------------------------
module rsi_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rsi_pkg::ctl_t  in_ctl,
  input  rsi_pkg::prep_t in_op,
  output rsi_pkg::ctl_t  out_ctl,
  output rsi_pkg::prod_t out_prod
);
  import rsi_pkg::*;

  ctl_t              st_ctl [MUL_SLICES];
  logic [Q_W-1:0]    st_q   [MUL_SLICES];
  logic [A_W-1:0]    st_a   [MUL_SLICES];
  logic [CM_W-1:0]   st_cm  [MUL_SLICES];
  logic [PROD_W-1:0] st_hh  [MUL_SLICES];
  logic [PROD_W-1:0] st_ac  [MUL_SLICES];

  for (genvar k = 0; k < MUL_SLICES; k++) begin : g_slice
    ctl_t                    src_ctl;
    logic [Q_W-1:0]          src_q;
    logic [A_W-1:0]          src_a;
    logic [CM_W-1:0]         src_cm;
    logic [PROD_W-1:0]       src_hh, src_ac;
    logic [Q_W+SLICE_W-1:0]  pp_hh;
    logic [A_W+SLICE_W-1:0]  pp_ac;

    if (k == 0) begin : g_first
      assign src_ctl = in_ctl;
      assign src_q   = in_op.q;
      assign src_a   = in_op.a;
      assign src_cm  = in_op.cm;
      assign src_hh  = '0;
      assign src_ac  = '0;
    end else begin : g_next
      assign src_ctl = st_ctl[k-1];
      assign src_q   = st_q[k-1];
      assign src_a   = st_a[k-1];
      assign src_cm  = st_cm[k-1];
      assign src_hh  = st_hh[k-1];
      assign src_ac  = st_ac[k-1];
    end

    assign pp_hh = src_q * src_q[k*SLICE_W +: SLICE_W];
    assign pp_ac = src_a * src_cm[k*SLICE_W +: SLICE_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[k] <= '0;
      end else if (en) begin
        st_ctl[k] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[k]  <= src_q;
        st_a[k]  <= src_a;
        st_cm[k] <= src_cm;
        st_hh[k] <= src_hh + (PROD_W'(pp_hh) << (k * SLICE_W));
        st_ac[k] <= src_ac + (PROD_W'(pp_ac) << (k * SLICE_W));
      end
    end
  end

  assign out_ctl       = st_ctl[MUL_SLICES-1];
  assign out_prod.q    = st_q[MUL_SLICES-1];
  assign out_prod.a    = st_a[MUL_SLICES-1];
  assign out_prod.hh   = st_hh[MUL_SLICES-1];
  assign out_prod.ac   = st_ac[MUL_SLICES-1];

endmodule

// ----- design/rsi_sqrt.sv -----
// ----------------------------------------------------------------------------
// rsi_sqrt: discriminant test and pipelined integer square root
// One stage forms h^2 - a*c, then one root bit is resolved per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rsi_pkg::ctl_t  in_ctl,
  input  rsi_pkg::prod_t in_prod,
  output rsi_pkg::ctl_t  out_ctl,
  output rsi_pkg::root_t out_root
);
  import rsi_pkg::*;

  ctl_t              d_ctl;
  logic [X_W-1:0]    d_x;
  logic [Q_W-1:0]    d_q;
  logic [A_W-1:0]    d_a;
  logic [PROD_W-1:0] diff;
  logic              disc_ok;

  ctl_t              st_ctl  [R_W];
  logic [X_W-1:0]    st_x    [R_W];
  logic [REM_W-1:0]  st_rem  [R_W];
  logic [R_W-1:0]    st_root [R_W];
  logic [Q_W-1:0]    st_q    [R_W];
  logic [A_W-1:0]    st_a    [R_W];

  assign disc_ok = in_prod.hh >= in_prod.ac;
  assign diff    = in_prod.hh - in_prod.ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else if (en) begin
      d_ctl.valid  <= in_ctl.valid;
      d_ctl.status <= in_ctl.status;
      d_ctl.calc   <= in_ctl.calc & disc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_x <= {diff, {(2*FRAC_BITS){1'b0}}};
      d_q <= in_prod.q;
      d_a <= in_prod.a;
    end
  end

  for (genvar i = 0; i < R_W; i++) begin : g_bit
    ctl_t             src_ctl;
    logic [X_W-1:0]   src_x;
    logic [REM_W-1:0] src_rem, rem_sh, trial;
    logic [R_W-1:0]   src_root;
    logic [Q_W-1:0]   src_q;
    logic [A_W-1:0]   src_a;
    logic             take;

    if (i == 0) begin : g_first
      assign src_ctl  = d_ctl;
      assign src_x    = d_x;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_q    = d_q;
      assign src_a    = d_a;
    end else begin : g_next
      assign src_ctl  = st_ctl[i-1];
      assign src_x    = st_x[i-1];
      assign src_rem  = st_rem[i-1];
      assign src_root = st_root[i-1];
      assign src_q    = st_q[i-1];
      assign src_a    = st_a[i-1];
    end

    assign rem_sh = {src_rem[REM_W-3:0], src_x[X_W-1 -: 2]};
    assign trial  = {src_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[i] <= '0;
      end else if (en) begin
        st_ctl[i] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_x[i]    <= src_x << 2;
        st_rem[i]  <= take ? rem_sh - trial : rem_sh;
        st_root[i] <= {src_root[R_W-2:0], take};
        st_q[i]    <= src_q;
        st_a[i]    <= src_a;
      end
    end
  end

  assign out_ctl          = st_ctl[R_W-1];
  assign out_root.q       = st_q[R_W-1];
  assign out_root.a       = st_a[R_W-1];
  assign out_root.root    = st_root[R_W-1];
  assign out_root.inexact = st_rem[R_W-1] != '0;

endmodule

// ----- design/rsi_div.sv -----
// ----------------------------------------------------------------------------
// rsi_div: nearer root numerator and pipelined division by a
// Two stages form and range-check the numerator, then one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module rsi_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rsi_pkg::ctl_t  in_ctl,
  input  rsi_pkg::root_t in_root,
  output logic           out_valid,
  output rsi_pkg::rsp_t  out_rsp
);
  import rsi_pkg::*;

  ctl_t           y0_ctl, y1_ctl;
  logic [Y_W-1:0] y0_y, y1_y;
  logic [A_W-1:0] y0_a, y1_a;
  logic           y1_sat;

  ctl_t              st_ctl [DIST_W];
  logic              st_sat [DIST_W];
  logic [Y_W-1:0]    st_y   [DIST_W];
  logic [A_W-1:0]    st_a   [DIST_W];
  logic [DIST_W-1:0] st_quo [DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      y0_ctl <= '0;
      y1_ctl <= '0;
    end else if (en) begin
      y0_ctl <= in_ctl;
      y1_ctl <= y0_ctl;
    end
  end

  // An inexact root is rounded up, so the numerator rounds down.
  always_ff @(posedge clk) begin
    if (en) begin
      y0_y   <= {in_root.q, {FRAC_BITS{1'b0}}} - Y_W'(in_root.root) - Y_W'(in_root.inexact);
      y0_a   <= in_root.a;
      y1_y   <= y0_y;
      y1_a   <= y0_a;
      y1_sat <= DIV_W'(y0_y) >= (DIV_W'(y0_a) << DIST_W);
    end
  end

  for (genvar j = 0; j < DIST_W; j++) begin : g_quo
    localparam int SH = DIST_W - 1 - j;
    ctl_t              src_ctl;
    logic              src_sat;
    logic [Y_W-1:0]    src_y;
    logic [A_W-1:0]    src_a;
    logic [DIST_W-1:0] src_quo;
    logic [DIV_W-1:0]  shifted;
    logic              fits;

    if (j == 0) begin : g_first
      assign src_ctl = y1_ctl;
      assign src_sat = y1_sat;
      assign src_y   = y1_y;
      assign src_a   = y1_a;
      assign src_quo = '0;
    end else begin : g_next
      assign src_ctl = st_ctl[j-1];
      assign src_sat = st_sat[j-1];
      assign src_y   = st_y[j-1];
      assign src_a   = st_a[j-1];
      assign src_quo = st_quo[j-1];
    end

    assign shifted = DIV_W'(src_a) << SH;
    assign fits    = DIV_W'(src_y) >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[j] <= '0;
      end else if (en) begin
        st_ctl[j] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_sat[j] <= src_sat;
        st_y[j]   <= fits ? src_y - shifted[Y_W-1:0] : src_y;
        st_a[j]   <= src_a;
        st_quo[j] <= {src_quo[DIST_W-2:0], fits};
      end
    end
  end

  always_comb begin
    out_valid = st_ctl[DIST_W-1].valid;
    if (st_ctl[DIST_W-1].calc) begin
      out_rsp.status   = ST_HIT;
      out_rsp.distance = st_sat[DIST_W-1] ? '1 : st_quo[DIST_W-1];
    end else begin
      out_rsp.status   = st_ctl[DIST_W-1].status;
      out_rsp.distance = '0;
    end
  end

endmodule

// ----- design/ray_sphere_intersect_unit.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit: streaming ray/sphere intersection test
// Solves a*t^2 + 2*h*t + c = 0 exactly and reports miss, hit with the nearer
// root in unsigned fixed point, or origin inside the sphere.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  ---------------------------------------------------
//   req      in         ray origin, direction, sphere centre and radius
//   rsp      out        status and distance, one per request
//
// One request may be taken every cycle. A request passes 126 registers: five
// setup stages, three product stages, one discriminant stage, one square root
// stage per root bit, two numerator stages, thirty-two divider stages and the
// output register. Requests are held off while the skid register is full.
// Reset is synchronous and clears every valid bit; payload is not reset.
// A stalled response is held in the output register, and a second finished
// response lands in a skid register; the pipeline freezes only while the skid
// register is full, so no request is lost or repeated.
//
module ray_sphere_intersect_unit (
  input logic        clk,
  input logic        rst,
  rsi_req_if.sink    req,
  rsi_rsp_if.source  rsp
);
  import rsi_pkg::*;

  ray_t  ray;
  logic  en;
  ctl_t  prep_ctl, mul_ctl, sqrt_ctl;
  prep_t prep_op;
  prod_t mul_prod;
  root_t sqrt_root;
  logic  tail_valid;
  rsp_t  tail_rsp;

  logic  out_valid, skid_valid;
  rsp_t  out_rsp, skid_rsp;
  logic  take_out;

  assign ray.origin_x = req.origin_x;
  assign ray.origin_y = req.origin_y;
  assign ray.origin_z = req.origin_z;
  assign ray.dir_x    = req.dir_x;
  assign ray.dir_y    = req.dir_y;
  assign ray.dir_z    = req.dir_z;
  assign ray.center_x = req.center_x;
  assign ray.center_y = req.center_y;
  assign ray.center_z = req.center_z;
  assign ray.radius   = req.radius;

  // The whole pipeline advances together unless the skid register is full.
  assign en        = !skid_valid;
  assign req.ready = !skid_valid && !rst;

  rsi_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req.valid && req.ready),
    .in_ray   (ray),
    .out_ctl  (prep_ctl),
    .out_op   (prep_op)
  );

  rsi_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (prep_ctl),
    .in_op    (prep_op),
    .out_ctl  (mul_ctl),
    .out_prod (mul_prod)
  );

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (mul_ctl),
    .in_prod  (mul_prod),
    .out_ctl  (sqrt_ctl),
    .out_root (sqrt_root)
  );

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (sqrt_ctl),
    .in_root   (sqrt_root),
    .out_valid (tail_valid),
    .out_rsp   (tail_rsp)
  );

  // The output register refills when it is empty or being read; it prefers
  // the skid register, which always holds the older response.
  assign take_out = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= tail_valid;
      end
    end else if (tail_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_rsp <= skid_valid ? skid_rsp : tail_rsp;
    end
    if (!take_out && en) begin
      skid_rsp <= tail_rsp;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_rsp.status;
  assign rsp.distance = out_rsp.distance;

endmodule

// ----- design/rsi_checker.sv -----
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for the intersection unit
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [rsi_pkg::ST_W-1:0]  status,
  input logic [rsi_pkg::DIST_W-1:0] distance
);
  import rsi_pkg::*;

  // Only a hit carries a distance.
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_HIT) |-> distance == '0)
    else $error("distance set on a response that is not a hit");

  // A held response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(distance))
    else $error("stalled response changed");

  // Once the response side drains, requests are taken again next cycle.
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !req_ready && rsp_ready |=> req_ready)
    else $error("request side stayed blocked after the response was read");

  // Nothing comes out straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .distance  (rsp.distance)
);

// ----- test/ray_sphere_intersect_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit_tb: self-checking bench for the intersection unit
// A table of hand-built rays is walked first. Random rays follow: most are
// aimed at their sphere, some start inside it, the rest are noise. Responses
// are checked against a typed answer or an exact wide-integer quadratic solution.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit_tb;
  import rsi_pkg::*;

  localparam int RANDOM_RAYS = 630;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 200;

  // One row of the directed table; known rows carry a typed answer.
  typedef struct {
    ray_t              ray;
    bit                known;
    status_t           status;
    logic [DIST_W-1:0] distance;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsi_req_if req_ch ();
  rsi_rsp_if rsp_ch ();

  ray_sphere_intersect_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  rsp_t   pending_q[$];
  probe_t probes[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     n_miss = 0, n_hit = 0, n_inside = 0, n_saturated = 0;
  bit     hold_request = 1'b0;

  // Exact solution of a*t^2 + 2*h*t + c = 0 for the nearer root, done in
  // 128-bit and 256-bit integers so that nothing can overflow.
  function automatic rsp_t solve_ray(ray_t r);
    logic signed [127:0] v, w, vv, vw, ww, h, hn;
    logic [255:0] a, wsq, rfix, rsq, q, hh, ac, x, s, cand, y;
    rsp_t res;
    a = '0;
    h = '0;
    wsq = '0;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          v = $signed(r.dir_x);
          w = $signed(r.origin_x) - $signed(r.center_x);
        end
        1: begin
          v = $signed(r.dir_y);
          w = $signed(r.origin_y) - $signed(r.center_y);
        end
        default: begin
          v = $signed(r.dir_z);
          w = $signed(r.origin_z) - $signed(r.center_z);
        end
      endcase
      vv = v * v;
      vw = v * w;
      ww = w * w;
      a = a + vv;
      h = h + vw;
      wsq = wsq + ww;
    end
    rfix = r.radius;
    rfix = rfix << FRAC_BITS;
    rsq = rfix * rfix;
    res.status = ST_MISS;
    res.distance = '0;
    if (a != 0) begin
      if (wsq < rsq) begin
        res.status = ST_INSIDE;
      end else if (wsq == rsq) begin
        // Origin on the surface: a hit at zero unless the ray points outwards.
        if (h <= 0) res.status = ST_HIT;
      end else if (h < 0) begin
        hn = -h;
        q = hn;
        hh = q * q;
        ac = a * (wsq - rsq);
        if (hh >= ac) begin
          x = (hh - ac) << (2 * FRAC_BITS);
          s = '0;
          for (int b = 95; b >= 0; b--) begin
            cand = s | (256'd1 << b);
            if (cand * cand <= x) s = cand;
          end
          // Round the root up when inexact so the distance is floored.
          y = (q << FRAC_BITS) - s;
          if (s * s != x) y = y - 1;
          res.status = ST_HIT;
          if (y >= (a << 32)) res.distance = '1;
          else res.distance = DIST_W'(y / a);
        end
      end
    end
    return res;
  endfunction

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int kx, int ky, int kz, int rad);
    ray_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    r.center_x = kx;
    r.center_y = ky;
    r.center_z = kz;
    r.radius = RAD_W'(rad);
    return r;
  endfunction

  function automatic void add_probe(ray_t r, bit known, status_t st, logic [31:0] d);
    probe_t p;
    p.ray = r;
    p.known = known;
    p.status = st;
    p.distance = d;
    probes.insert(probes.size(), p);
  endfunction

  // Random rays. Most are aimed at the sphere so that hits,
  // tangents and near misses are common; some start inside; the rest are
  // raw noise over the full field ranges.
  function automatic ray_t random_ray();
    int kind, cx, cy, cz, ox, oy, oz, sh, rad, span;
    ray_t r;
    kind = $urandom_range(0, 9);
    cx = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    cy = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    cz = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    rad = $urandom_range(1, 300);
    if (kind <= 5) begin
      span = 1 << $urandom_range(18, 28);
      ox = cx + int'($urandom_range(0, span)) - span / 2;
      oy = cy + int'($urandom_range(0, span)) - span / 2;
      oz = cz + int'($urandom_range(0, span)) - span / 2;
      sh = $urandom_range(0, 10);
      r = make_ray(ox, oy, oz,
                   ((cx - ox) >>> sh) + int'($urandom_range(0, 255)) - 128,
                   ((cy - oy) >>> sh) + int'($urandom_range(0, 255)) - 128,
                   ((cz - oz) >>> sh) + int'($urandom_range(0, 255)) - 128,
                   cx, cy, cz, rad);
    end else if (kind == 6) begin
      span = rad << 15;
      r = make_ray(cx + int'($urandom_range(0, span)) - span / 2,
                   cy + int'($urandom_range(0, span)) - span / 2,
                   cz + int'($urandom_range(0, span)) - span / 2,
                   $urandom, $urandom, $urandom, cx, cy, cz, rad);
    end else begin
      r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom_range(0, 65535));
    end
    return r;
  endfunction

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drive_request(ray_t r);
    req_ch.valid    <= 1'b1;
    req_ch.origin_x <= r.origin_x;
    req_ch.origin_y <= r.origin_y;
    req_ch.origin_z <= r.origin_z;
    req_ch.dir_x    <= r.dir_x;
    req_ch.dir_y    <= r.dir_y;
    req_ch.dir_z    <= r.dir_z;
    req_ch.center_x <= r.center_x;
    req_ch.center_y <= r.center_y;
    req_ch.center_z <= r.center_z;
    req_ch.radius   <= r.radius;
  endtask

  // Sender. A request is offered and held until the unit takes it; the
  // expected response is queued at the same edge. Valid is dropped only
  // when a gap follows, so it is never lowered and raised in one step.
  initial begin
    probe_t p;
    rsp_t   e;
    int     gap;
    int     total;
    int     one;
    one = 1 << FRAC_BITS;
    req_ch.valid = 1'b0;
    req_ch.origin_x = '0;
    req_ch.origin_y = '0;
    req_ch.origin_z = '0;
    req_ch.dir_x = '0;
    req_ch.dir_y = '0;
    req_ch.dir_z = '0;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.center_z = '0;
    req_ch.radius = '0;

    // Zero direction is always a miss.
    add_probe(make_ray(-10 * one, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, ST_MISS, 0);
    // Plain hit: from x = -10 towards a unit sphere, near root at t = 9.
    add_probe(make_ray(-10 * one, 0, 0, one, 0, 0, 0, 0, 0, 1), 1, ST_HIT, 32'h0009_0000);
    // Tangent ray, zero discriminant, touching at t = 10.
    add_probe(make_ray(-10 * one, one, 0, one, 0, 0, 0, 0, 0, 1), 1, ST_HIT, 32'h000A_0000);
    // Negative discriminant.
    add_probe(make_ray(-10 * one, 5 * one, 0, one, 0, 0, 0, 0, 0, 1), 1, ST_MISS, 0);
    // Both roots behind the origin.
    add_probe(make_ray(-10 * one, 0, 0, -one, 0, 0, 0, 0, 0, 1), 1, ST_MISS, 0);
    // Origin on the surface, heading in, then heading out.
    add_probe(make_ray(-one, 0, 0, one, 0, 0, 0, 0, 0, 1), 1, ST_HIT, 0);
    add_probe(make_ray(-one, 0, 0, -one, 0, 0, 0, 0, 0, 1), 1, ST_MISS, 0);
    // Origin strictly inside.
    add_probe(make_ray(0, 0, 0, one, 0, 0, 0, 0, 0, 1), 1, ST_INSIDE, 0);
    add_probe(make_ray(0, 0, 0, 0, 0, -1, 0, 0, 0, 65535), 1, ST_INSIDE, 0);
    // Zero radius with the origin at the centre sits on the surface.
    add_probe(make_ray(0, 0, 0, 0, one, 0, 0, 0, 0, 0), 1, ST_HIT, 0);
    // A tiny direction makes the hit too far to represent.
    add_probe(make_ray(-10 * one, 0, 0, 1, 0, 0, 0, 0, 0, 1), 1, ST_HIT, 32'hFFFF_FFFF);
    // Field extremes, left to the predictor.
    add_probe(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535), 0, ST_MISS, 0);
    add_probe(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, ST_MISS, 0);
    add_probe(make_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 65535), 0, ST_MISS, 0);
    add_probe(make_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                       32'h7FFF_FFFF, 0, 0, 65535), 0, ST_MISS, 0);
    add_probe(make_ray(-300 * one, 0, 0, 32'h7FFF_FFFF, 1, -1, 0, 0, 0, 200), 0, ST_MISS, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    total = probes.size() + RANDOM_RAYS;
    for (int n = 0; n < total; n++) begin
      if (n < probes.size()) p = probes[n];
      else p.ray = random_ray();
      // Long receiver hold while we keep offering: the pipeline must fill.
      if (n == 300) hold_request = 1'b1;
      drive_request(p.ray);
      do @(posedge clk); while (!req_ch.ready);
      if (n < probes.size() && p.known) begin
        e.status = p.status;
        e.distance = p.distance;
      end else begin
        e = solve_ray(p.ray);
      end
      pending_q.insert(pending_q.size(), e);
      gap = (n > 200 && n < 330) ? 0 : random_gap();
      // Once, let the unit drain completely before carrying on.
      if (n == 450) begin
        req_ch.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end else if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d responses: %0d hits (%0d saturated), %0d inside, %0d misses.",
             n_hit + n_inside + n_miss, n_hit, n_saturated, n_inside, n_miss);
    $display("Directed rays, aimed and random rays, one long output stall and one drain.");
    if (mismatches == 0) begin
      $display("ray_sphere_intersect_unit: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("ray_sphere_intersect_unit: mismatch");
    end
    $finish;
  end

  // Receiver. Ready idles at random, and once holds off for a long stretch.
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        int gap;
        gap = random_gap();
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Response checker: each accepted response against the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected response: status %0d distance %h",
                   rsp_ch.status, rsp_ch.distance);
      end else begin
        e = pending_q.pop_front();
        if (rsp_ch.status !== e.status || rsp_ch.distance !== e.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Response wrong: expected status %0d distance %h, got %0d %h",
                     e.status, e.distance, rsp_ch.status, rsp_ch.distance);
        end
        case (e.status)
          ST_HIT: begin
            n_hit++;
            if (e.distance == '1) n_saturated++;
          end
          ST_INSIDE: n_inside++;
          default: n_miss++;
        endcase
      end
    end
  end

  // Watchdog: too long without any request or response moving.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout with %0d responses outstanding", pending_q.size());
      $display("ray_sphere_intersect_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
design/rsi_pkg.sv
design/rsi_if.sv
design/rsi_prep.sv
design/rsi_mul.sv
design/rsi_sqrt.sv
design/rsi_div.sv
design/ray_sphere_intersect_unit.sv
design/rsi_checker.sv
test/ray_sphere_intersect_unit_tb.sv
